// ===== rtl/flcl_pkg.sv =====
package flcl_pkg;

  // slot status codes as kept in the status memory
  localparam logic [1:0] ST_READ    = 2'd0;
  localparam logic [1:0] ST_WRITTEN = 2'd2;
  localparam logic [1:0] ST_CLEAN   = 2'd3;

  // request modes
  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_RECOVER = 2'd2;
  localparam logic [1:0] MODE_ERASE   = 2'd3;

  // result status codes
  localparam logic [1:0] RES_OK        = 2'd0;
  localparam logic [1:0] RES_EMPTY     = 2'd1;
  localparam logic [1:0] RES_DIRTY     = 2'd2;
  localparam logic [1:0] RES_SCAN_FAIL = 2'd3;

  localparam int unsigned FIELD_BITS = 16;

endpackage

// ===== rtl/flcl_ram.sv =====
module flcl_ram #(
  parameter int unsigned WIDTH  = 2,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DEPTH  = 256
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read: rdata shows the word at raddr in the next cycle
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/flash_circular_log_manager.sv =====
// channel  | direction | handshake            | payload
// request  | in        | in_valid / in_ready   | mode, write_payload
// result   | out       | out_valid / out_ready | read_payload, status
//
// one request at a time; a write that crosses a sector also checks the new head sector
// a read of the last record in a sector erases that sector with a clearing sweep
// recover reads one status slot per cycle while it searches for the head, then the tail
// erase all sweeps every slot clean, as does the clearing pass after reset
// the single read port of the status memory sets this pace
// a request is taken while the previous result still waits in the output register
module flash_circular_log_manager #(
  parameter int unsigned SECTOR_COUNT     = 16,
  parameter int unsigned SLOTS_PER_SECTOR = 16,
  parameter int unsigned PAYLOAD_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [flcl_pkg::FIELD_BITS-1:0] write_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [flcl_pkg::FIELD_BITS-1:0] read_payload,
  output logic [1:0]  status
);
  import flcl_pkg::*;

  // slot address is {sector, offset}; offsets padded to a power of two
  localparam int unsigned SEC_W  = $clog2(SECTOR_COUNT);
  localparam int unsigned OFF_W  = $clog2(SLOTS_PER_SECTOR);
  localparam int unsigned ADDR_W = SEC_W + OFF_W;
  localparam int unsigned DEPTH  = SECTOR_COUNT * (1 << OFF_W);
  localparam int unsigned CNT_W  = ADDR_W + 1;
  localparam int unsigned TOTAL  = SECTOR_COUNT * SLOTS_PER_SECTOR;

  localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTOR_COUNT - 1);
  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(SLOTS_PER_SECTOR - 1);

  // sequencer states
  localparam logic [3:0] S_CLR    = 4'd0;  // status clearing sweep
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_WRCHK  = 4'd2;  // check new head sector start
  localparam logic [3:0] S_RDDAT  = 4'd3;  // payload at tail arrives
  localparam logic [3:0] S_RCPREV = 4'd4;  // status of the very last slot
  localparam logic [3:0] S_RCB    = 4'd5;  // sector start during head scan
  localparam logic [3:0] S_RCE    = 4'd6;  // sector end during head scan
  localparam logic [3:0] S_RCSCAN = 4'd7;  // walk inside the head sector
  localparam logic [3:0] S_RCT1   = 4'd8;  // find first used sector after head
  localparam logic [3:0] S_RCT2   = 4'd9;  // skip read slots to the tail
  localparam logic [3:0] S_FIN    = 4'd10; // hand result to the output register

  function automatic logic [SEC_W-1:0] nsec(input logic [SEC_W-1:0] s);
    return (s == SEC_LAST) ? '0 : s + SEC_W'(1);
  endfunction

  logic [3:0]       state, state_next;
  logic [SEC_W-1:0] head_sec, head_sec_next, tail_sec, tail_sec_next;
  logic [OFF_W-1:0] head_off, head_off_next, tail_off, tail_off_next;
  logic [SEC_W-1:0] cs, cs_next, ra_sec, ra_sec_next;
  logic [OFF_W-1:0] off, off_next, ra_off, ra_off_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [1:0]       prev, prev_next;
  logic             clr_all, clr_all_next, clr_reply, clr_reply_next;
  logic [1:0]       res_status, res_status_next;
  logic [FIELD_BITS-1:0] res_payload, res_payload_next;

  // memory ports
  logic              st_we;
  logic [ADDR_W-1:0] st_waddr;
  logic [1:0]        st_wdata, st_rdata;
  logic              pl_we;
  logic [PAYLOAD_BITS-1:0] pl_wdata, pl_rdata;
  logic [63:0]       wr_ext, rd_ext;

  // scan outcome flags, applied after the state case
  logic go_tail, go_none, go_fail;

  assign wr_ext   = 64'(write_payload);
  assign pl_wdata = wr_ext[PAYLOAD_BITS-1:0];
  assign rd_ext   = 64'(pl_rdata);

  // status memory: a read whose data is used never hits a slot written in the same cycle,
  // so no forwarding is needed
  flcl_ram #(.WIDTH(2), .ADDR_W(ADDR_W), .DEPTH(DEPTH)) u_status (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr ({ra_sec_next, ra_off_next}),
    .rdata (st_rdata)
  );

  // payload memory: read address follows the tail, written at the head
  flcl_ram #(.WIDTH(PAYLOAD_BITS), .ADDR_W(ADDR_W), .DEPTH(DEPTH)) u_payload (
    .clk   (clk),
    .we    (pl_we),
    .waddr ({head_sec, head_off}),
    .wdata (pl_wdata),
    .raddr ({tail_sec, tail_off}),
    .rdata (pl_rdata)
  );

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next       = state;
    head_sec_next    = head_sec;
    head_off_next    = head_off;
    tail_sec_next    = tail_sec;
    tail_off_next    = tail_off;
    cs_next          = cs;
    off_next         = off;
    cnt_next         = cnt;
    prev_next        = prev;
    clr_all_next     = clr_all;
    clr_reply_next   = clr_reply;
    res_status_next  = res_status;
    res_payload_next = res_payload;
    ra_sec_next      = ra_sec;
    ra_off_next      = ra_off;
    st_we            = 1'b0;
    st_waddr         = {head_sec, head_off};
    st_wdata         = ST_CLEAN;
    pl_we            = 1'b0;
    go_tail          = 1'b0;
    go_none          = 1'b0;
    go_fail          = 1'b0;

    case (state)
      S_CLR: begin
        st_we    = 1'b1;
        st_waddr = {cs, off};
        st_wdata = ST_CLEAN;
        if (off == OFF_LAST) begin
          off_next = '0;
          if (!clr_all || cs == SEC_LAST) begin
            state_next = clr_reply ? S_FIN : S_IDLE;
          end else begin
            cs_next = cs + SEC_W'(1);
          end
        end else begin
          off_next = off + OFF_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_payload_next = '0;
          res_status_next  = RES_OK;
          case (mode)
            MODE_WRITE: begin
              st_we    = 1'b1;
              st_wdata = ST_WRITTEN;
              pl_we    = 1'b1;
              if (head_off != OFF_LAST) begin
                head_off_next = head_off + OFF_W'(1);
                state_next    = S_FIN;
              end else begin
                head_sec_next = nsec(head_sec);
                head_off_next = '0;
                if (nsec(head_sec) == tail_sec) begin
                  tail_sec_next = nsec(tail_sec);
                  tail_off_next = '0;
                end
                ra_sec_next = nsec(head_sec);
                ra_off_next = '0;
                state_next  = S_WRCHK;
              end
            end
            MODE_READ: begin
              if (head_sec == tail_sec && head_off == tail_off) begin
                res_status_next = RES_EMPTY;
                state_next      = S_FIN;
              end else begin
                state_next = S_RDDAT;
              end
            end
            MODE_RECOVER: begin
              ra_sec_next = SEC_LAST;
              ra_off_next = OFF_LAST;
              state_next  = S_RCPREV;
            end
            default: begin
              head_sec_next  = '0;
              head_off_next  = '0;
              tail_sec_next  = '0;
              tail_off_next  = '0;
              cs_next        = '0;
              off_next       = '0;
              clr_all_next   = 1'b1;
              clr_reply_next = 1'b1;
              state_next     = S_CLR;
            end
          endcase
        end
      end
      S_WRCHK: begin
        if (st_rdata != ST_CLEAN) begin
          res_status_next = RES_DIRTY;
        end
        state_next = S_FIN;
      end
      S_RDDAT: begin
        res_payload_next = rd_ext[FIELD_BITS-1:0];
        if (tail_off == OFF_LAST) begin
          // last record of its sector: erase the sector and jump
          tail_sec_next  = nsec(tail_sec);
          tail_off_next  = '0;
          cs_next        = tail_sec;
          off_next       = '0;
          clr_all_next   = 1'b0;
          clr_reply_next = 1'b1;
          state_next     = S_CLR;
        end else begin
          st_we         = 1'b1;
          st_waddr      = {tail_sec, tail_off};
          st_wdata      = ST_READ;
          tail_off_next = tail_off + OFF_W'(1);
          state_next    = S_FIN;
        end
      end
      S_RCPREV: begin
        prev_next   = st_rdata;
        cs_next     = '0;
        ra_sec_next = '0;
        ra_off_next = '0;
        state_next  = S_RCB;
      end
      S_RCB: begin
        if (st_rdata == ST_CLEAN) begin
          if (prev != ST_CLEAN) begin
            head_sec_next = cs;
            head_off_next = '0;
            go_tail       = 1'b1;
          end else if (cs == SEC_LAST) begin
            go_none = 1'b1;
          end else begin
            cs_next     = cs + SEC_W'(1);
            ra_sec_next = cs + SEC_W'(1);
            ra_off_next = '0;
          end
        end else begin
          ra_off_next = OFF_LAST;
          state_next  = S_RCE;
        end
      end
      S_RCE: begin
        if (st_rdata != ST_CLEAN) begin
          prev_next = st_rdata;
          if (cs == SEC_LAST) begin
            go_none = 1'b1;
          end else begin
            cs_next     = cs + SEC_W'(1);
            ra_sec_next = cs + SEC_W'(1);
            ra_off_next = '0;
            state_next  = S_RCB;
          end
        end else begin
          off_next    = OFF_W'(1);
          ra_off_next = OFF_W'(1);
          state_next  = S_RCSCAN;
        end
      end
      S_RCSCAN: begin
        if (st_rdata == ST_CLEAN) begin
          head_sec_next = cs;
          head_off_next = off;
          go_tail       = 1'b1;
        end else begin
          off_next    = off + OFF_W'(1);
          ra_off_next = off + OFF_W'(1);
        end
      end
      S_RCT1: begin
        if (st_rdata != ST_CLEAN) begin
          off_next   = '0;
          cnt_next   = '0;
          state_next = S_RCT2;
        end else if (cnt == CNT_W'(SECTOR_COUNT - 1)) begin
          go_fail = 1'b1;
        end else begin
          cnt_next    = cnt + CNT_W'(1);
          cs_next     = nsec(cs);
          ra_sec_next = nsec(cs);
          ra_off_next = '0;
        end
      end
      S_RCT2: begin
        if (st_rdata != ST_READ) begin
          tail_sec_next = cs;
          tail_off_next = off;
          state_next    = S_FIN;
        end else if (cnt == CNT_W'(TOTAL)) begin
          go_fail = 1'b1;
        end else begin
          cnt_next = cnt + CNT_W'(1);
          if (off == OFF_LAST) begin
            cs_next     = nsec(cs);
            off_next    = '0;
            ra_sec_next = nsec(cs);
            ra_off_next = '0;
          end else begin
            off_next    = off + OFF_W'(1);
            ra_off_next = off + OFF_W'(1);
          end
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // head found: start the tail search at the next sector start
    if (go_tail) begin
      cs_next     = nsec(cs);
      cnt_next    = '0;
      ra_sec_next = nsec(cs);
      ra_off_next = '0;
      state_next  = S_RCT1;
    end
    // no head, or the tail scan failed: empty log at slot zero
    if (go_none || go_fail) begin
      head_sec_next = '0;
      head_off_next = '0;
      tail_sec_next = '0;
      tail_off_next = '0;
      state_next    = S_FIN;
    end
    if (go_fail) begin
      res_status_next = RES_SCAN_FAIL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      head_sec  <= '0;
      head_off  <= '0;
      tail_sec  <= '0;
      tail_off  <= '0;
      cs        <= '0;
      off       <= '0;
      clr_all   <= 1'b1;
      clr_reply <= 1'b0;
      ra_sec    <= '0;
      ra_off    <= '0;
    end else begin
      state     <= state_next;
      head_sec  <= head_sec_next;
      head_off  <= head_off_next;
      tail_sec  <= tail_sec_next;
      tail_off  <= tail_off_next;
      cs        <= cs_next;
      off       <= off_next;
      clr_all   <= clr_all_next;
      clr_reply <= clr_reply_next;
      ra_sec    <= ra_sec_next;
      ra_off    <= ra_off_next;
    end
  end

  // scan scratch and result holding registers
  always_ff @(posedge clk) begin
    cnt         <= cnt_next;
    prev        <= prev_next;
    res_status  <= res_status_next;
    res_payload <= res_payload_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_valid || out_ready)) begin
      read_payload <= res_payload;
      status       <= res_status;
    end
  end

endmodule

// ===== rtl/flcl_checker.sv =====
module flcl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  mode,
  input logic [flcl_pkg::FIELD_BITS-1:0] write_payload,
  input logic        out_valid,
  input logic        out_ready,
  input logic [flcl_pkg::FIELD_BITS-1:0] read_payload,
  input logic [1:0]  status
);
  import flcl_pkg::*;

  logic [1:0] pend;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // requests taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (in_acc && !out_acc) begin
      pend <= pend + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend <= pend - 2'd1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_payload) && $stable(status))
    else $error("result changed while stalled");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != RES_OK |-> read_payload == '0)
    else $error("payload on a failed request");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pend != 2'd0)
    else $error("result without a request");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pend != 2'd3)
    else $error("too many requests in flight");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind flash_circular_log_manager flcl_checker u_flcl_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .mode          (mode),
  .write_payload (write_payload),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .read_payload  (read_payload),
  .status        (status)
);

// ===== test/flash_circular_log_checker.sv =====
module flash_circular_log_checker #(
  parameter int unsigned SECTOR_COUNT     = 16,
  parameter int unsigned SLOTS_PER_SECTOR = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [15:0] write_payload,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] read_payload,
  input  logic [1:0]  status,
  output int          error_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import flcl_pkg::*;

  localparam int unsigned TOTAL = SECTOR_COUNT * SLOTS_PER_SECTOR;

  typedef struct packed {
    logic [15:0] payload;
    logic [1:0]  code;
  } log_result_t;

  logic [1:0]  slot_state [TOTAL];
  logic [15:0] slot_data [TOTAL];
  int unsigned head_pos, tail_pos;
  log_result_t result_queue [$];

  function automatic int unsigned sector_base(int unsigned s);
    return (s / SLOTS_PER_SECTOR) * SLOTS_PER_SECTOR;
  endfunction

  function automatic int unsigned next_base(int unsigned s);
    return (sector_base(s) + SLOTS_PER_SECTOR) % TOTAL;
  endfunction

  function automatic bit last_in_sector(int unsigned s);
    return (s % SLOTS_PER_SECTOR) == SLOTS_PER_SECTOR - 1;
  endfunction

  function automatic logic [1:0] log_write(logic [15:0] value);
    int unsigned h;
    h = head_pos;
    slot_state[h] = ST_WRITTEN;
    slot_data[h] = value;
    if (!last_in_sector(h)) begin
      head_pos = h + 1;
      return RES_OK;
    end
    head_pos = next_base(h);
    if (sector_base(head_pos) == sector_base(tail_pos)) tail_pos = next_base(tail_pos);
    return (slot_state[head_pos] == ST_CLEAN) ? RES_OK : RES_DIRTY;
  endfunction

  function automatic logic [1:0] log_read(output logic [15:0] value);
    int unsigned t, base;
    t = tail_pos;
    value = '0;
    if (head_pos == tail_pos) return RES_EMPTY;
    value = slot_data[t];
    if (last_in_sector(t)) begin
      base = sector_base(t);
      for (int i = 0; i < SLOTS_PER_SECTOR; i++) slot_state[base + i] = ST_CLEAN;
      tail_pos = next_base(t);
    end else begin
      slot_state[t] = ST_READ;
      tail_pos = t + 1;
    end
    return RES_OK;
  endfunction

  function automatic logic [1:0] log_recover();
    int unsigned cur, n;
    bit found;
    logic [1:0] prev, b, e;
    cur = 0;
    found = 0;
    prev = slot_state[TOTAL - 1];
    while (cur < TOTAL) begin
      b = slot_state[cur];
      if (b == ST_CLEAN) begin
        if (prev != ST_CLEAN) begin
          found = 1;
          break;
        end
        cur += SLOTS_PER_SECTOR;
        continue;
      end
      e = slot_state[cur + SLOTS_PER_SECTOR - 1];
      if (e != ST_CLEAN) begin
        prev = e;
        cur += SLOTS_PER_SECTOR;
        continue;
      end
      do cur++; while (slot_state[cur] != ST_CLEAN);
      found = 1;
      break;
    end
    if (!found) begin
      head_pos = 0;
      tail_pos = 0;
      return RES_OK;
    end
    head_pos = cur;
    n = 0;
    forever begin
      if (n >= SECTOR_COUNT) begin
        head_pos = 0;
        tail_pos = 0;
        return RES_SCAN_FAIL;
      end
      cur = next_base(cur);
      if (slot_state[cur] != ST_CLEAN) break;
      n++;
    end
    n = 0;
    while (slot_state[cur] == ST_READ) begin
      if (n >= TOTAL) begin
        head_pos = 0;
        tail_pos = 0;
        return RES_SCAN_FAIL;
      end
      cur = last_in_sector(cur) ? next_base(cur) : cur + 1;
      n++;
    end
    tail_pos = cur;
    return RES_OK;
  endfunction

  function automatic log_result_t log_step(logic [1:0] m, logic [15:0] value);
    log_result_t r;
    r.payload = '0;
    case (m)
      MODE_WRITE:   r.code = log_write(value);
      MODE_READ:    r.code = log_read(r.payload);
      MODE_RECOVER: r.code = log_recover();
      default: begin
        for (int i = 0; i < TOTAL; i++) slot_state[i] = ST_CLEAN;
        head_pos = 0;
        tail_pos = 0;
        r.code = RES_OK;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    log_result_t want;
    if (rst) begin
      for (int i = 0; i < TOTAL; i++) begin
        slot_state[i] = ST_CLEAN;
        slot_data[i] = '0;
      end
      head_pos = 0;
      tail_pos = 0;
      result_queue.delete();
      error_count <= 0;
      pending_count <= 0;
    end else begin
      if (in_valid && in_ready) result_queue.push_back(log_step(mode, write_payload));
      if (out_valid && out_ready) begin
        if (result_queue.size() == 0) begin
          error_count <= error_count + 1;
          if (error_count < 10) $display("unexpected result payload=%h status=%0d",
                                         read_payload, status);
        end else begin
          want = result_queue.pop_front();
          if (want.payload !== read_payload || want.code !== status) begin
            error_count <= error_count + 1;
            if (error_count < 10)
              $display("mismatch: expected payload=%h status=%0d, got payload=%h status=%0d",
                       want.payload, want.code, read_payload, status);
          end
        end
      end
      pending_count <= result_queue.size();
    end
  end
endmodule

// ===== test/flash_circular_log_manager_test.sv =====
module flash_circular_log_manager_test;
  timeunit 1ns;
  timeprecision 1ps;
  import flcl_pkg::*;

  logic        clk, rst;
  logic        in_valid, in_ready, out_valid, out_ready;
  logic [1:0]  mode, status;
  logic [15:0] write_payload, read_payload;
  int          error_count, pending_count;
  bit          quiet_phase;   // no idling near the end
  bit          long_hold;     // receiver held off for a long stretch
  // written-record count, tracked here but not used to gate reads
  int          live_records;

  flash_circular_log_manager dut (.*);

  flash_circular_log_checker checker_inst (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // generous overall limit for the whole run
  initial begin
    #100ms;
    $display("flash_circular_log_manager_test: done, errors");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off
  initial begin
    int burst;
    out_ready = 0;
    @(posedge clk iff !rst);
    forever begin
      if (long_hold) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 18);
        out_ready <= 0;
        repeat (burst) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  // hand one request over and wait for acceptance
  task automatic send_request(logic [1:0] m, logic [15:0] value);
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1;
    mode <= m;
    write_payload <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // records can be lost when the head overruns the tail; stay conservative
    if (m == MODE_WRITE) live_records++;
    else if (m == MODE_READ && live_records > 0) live_records--;
    else if (m != MODE_READ) live_records = 0;
  endtask

  task automatic drain_results();
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // a read is only safe if every slot it could reach was written since the
  // last erase; writes stop at 240 since the last erase so the log never wraps
  int wrote_total;

  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55 && wrote_total < 240) begin
      send_request(MODE_WRITE, 16'($urandom));
      wrote_total++;
    end else if (pick < 92) begin
      send_request(MODE_READ, 16'($urandom));
    end else if (pick < 96) begin
      send_request(MODE_RECOVER, 16'($urandom));
    end else begin
      send_request(MODE_ERASE, 16'($urandom));
      wrote_total = 0;
    end
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    mode = MODE_WRITE;
    write_payload = '0;
    quiet_phase = 0;
    long_hold = 0;
    live_records = 0;
    wrote_total = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty read, recover on a clean log, payload extremes
    send_request(MODE_READ, 16'hffff);
    send_request(MODE_RECOVER, '0);
    send_request(MODE_WRITE, 16'h0000);
    send_request(MODE_WRITE, 16'hffff);
    send_request(MODE_WRITE, 16'h5a5a);
    send_request(MODE_READ, '0);
    send_request(MODE_RECOVER, '0);
    send_request(MODE_READ, '0);
    send_request(MODE_READ, '0);
    send_request(MODE_READ, '0);
    // write a sector's worth so the head crosses, read four back, then erase all
    for (int i = 0; i < 16; i++) send_request(MODE_WRITE, 16'(i * 16'h1111));
    for (int i = 0; i < 4; i++) send_request(MODE_READ, '0);
    send_request(MODE_ERASE, '0);
    send_request(MODE_READ, '0);

    // long receiver hold-off while requests keep coming
    long_hold = 1;
    for (int i = 0; i < 20; i++) send_request(MODE_WRITE, 16'($urandom));
    drain_results();   // sender pause until everything is back

    // wrap the whole log once: head reenters dirty sectors, tail gets pushed
    send_request(MODE_ERASE, '0);
    for (int i = 0; i < 300; i++) send_request(MODE_WRITE, 16'($urandom));
    send_request(MODE_RECOVER, '0);
    for (int i = 0; i < 40; i++) send_request(MODE_READ, '0);
    send_request(MODE_RECOVER, '0);
    for (int i = 0; i < 40; i++) send_request(MODE_READ, '0);
    send_request(MODE_ERASE, '0);
    wrote_total = 0;

    // random part
    for (int i = 0; i < 1100; i++) begin
      if (i == 1000) quiet_phase = 1;
      random_request();
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (error_count == 0 && pending_count == 0)
      $display("flash_circular_log_manager_test: done, clean");
    else
      $display("flash_circular_log_manager_test: done, errors");
    $finish;
  end
endmodule

// ===== flash_circular_log_manager.f =====
rtl/flcl_pkg.sv
rtl/flcl_ram.sv
rtl/flash_circular_log_manager.sv
rtl/flcl_checker.sv
test/flash_circular_log_checker.sv
test/flash_circular_log_manager_test.sv
